/* src/php_pkg.sv */
`timescale 1ns / 1ps

package php_pkg;

    // Default sizes of the polygon table and of the coordinate format.
    localparam int DEF_MAX_POLYGONS    = 16;
    localparam int DEF_MAX_VERTICES    = 16;
    localparam int DEF_COORD_FRAC_BITS = 16;

    // Fixed field widths of the item, result, configuration and APB ports.
    localparam int SLOT_W  = 4;
    localparam int CFG_W   = 5;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Register map, by register index.
    localparam logic REG_POLYGONS_IN_USE = 1'b0;

    // Item operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // A polygon needs at least this many vertices to enclose anything.
    localparam int MIN_VERTS = 3;

    // Wait count after the last vertex read until the parity bit is final.
    localparam logic [1:0] DRAIN_LAST = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write_vertex;
        logic load_point;
        logic clear_parity;
        logic rd_en;
        logic rd_first;
    } php_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_poly;
    } php_status_t;

endpackage

/* src/php_dp.sv */
`timescale 1ns / 1ps

module php_dp
    import php_pkg::*;
#(
    parameter int MAX_POLYGONS    = DEF_MAX_POLYGONS,
    parameter int MAX_VERTICES    = DEF_MAX_VERTICES,
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
    localparam int PW   = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1,
    localparam int VW   = $clog2(MAX_VERTICES),
    localparam int CNTW = $clog2(MAX_VERTICES + 1),
    localparam int CW   = COORD_FRAC_BITS + 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  php_cmd_t          cmd,
    output php_status_t       status,
    input  logic [PW-1:0]     rd_poly,
    input  logic [VW-1:0]     rd_vert,
    output logic [CNTW-1:0]   poly_count,
    input  logic [SLOT_W-1:0] polygon_slot,
    input  logic [SLOT_W-1:0] vertex_slot,
    input  logic              vertex_last,
    input  logic [CW-1:0]     coord_u,
    input  logic [CW-1:0]     coord_v
);

    localparam int AW = PW + VW;
    localparam int DW = CW + 1;
    localparam int MW = 2 * DW;

    logic [2*CW-1:0] vmem [2**AW];
    logic [2*CW-1:0] mem_q_reg;
    logic            v1_reg;
    logic            first1_reg;

    logic [CNTW-1:0] counts_reg [2**PW];

    logic [CW-1:0] pu_reg;
    logic [CW-1:0] pv_reg;
    logic [CW-1:0] prev_u_reg;
    logic [CW-1:0] prev_v_reg;

    logic signed [DW-1:0] du_reg;
    logic signed [DW-1:0] duj_reg;
    logic signed [DW-1:0] dpv_reg;
    logic signed [DW-1:0] dv_reg;
    logic                 dvpos2_reg;
    logic                 cross2_reg;

    logic signed [MW-1:0] lhs_reg;
    logic signed [MW-1:0] rhs_reg;
    logic                 dvpos3_reg;
    logic                 cross3_reg;

    logic parity_reg;

    logic          wr_ok;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] ui;
    logic [CW-1:0] vi;
    logic          crosses;
    logic          left;

    // A vertex write outside the table is dropped.
    assign wr_ok = cmd.write_vertex && (polygon_slot < MAX_POLYGONS)
                   && (vertex_slot < MAX_VERTICES);
    assign wr_addr = {PW'(polygon_slot), VW'(vertex_slot)};

    // Vertex memory: one write port for items, one registered read port for the walk.
    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            vmem[wr_addr] <= {coord_u, coord_v};
        end
        if (cmd.rd_en)
        begin
            mem_q_reg <= vmem[{rd_poly, rd_vert}];
        end
    end

    // Vertex counts, cleared by reset; the last-vertex mark sets a count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < 2**PW; p++)
            begin
                counts_reg[p] <= '0;
            end
        end
        else if (wr_ok && vertex_last)
        begin
            counts_reg[PW'(polygon_slot)] <= CNTW'(vertex_slot) + CNTW'(1);
        end
    end

    assign poly_count = counts_reg[rd_poly];

    // Query point, held for the whole search.
    always_ff @(posedge clk)
    begin
        if (cmd.load_point)
        begin
            pu_reg <= coord_u;
            pv_reg <= coord_v;
        end
    end

    assign ui = mem_q_reg[2*CW-1:CW];
    assign vi = mem_q_reg[CW-1:0];

    // The edge straddles the horizontal line through the point.
    assign crosses = (vi > pv_reg) != (prev_v_reg > pv_reg);

    // Pipeline valid tags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            first1_reg <= 1'b0;
            cross2_reg <= 1'b0;
            cross3_reg <= 1'b0;
        end
        else
        begin
            v1_reg     <= cmd.rd_en;
            first1_reg <= cmd.rd_first;
            cross2_reg <= v1_reg && !first1_reg && crosses;
            cross3_reg <= cross2_reg;
        end
    end

    // Edge stage: keep the previous vertex and form the differences.
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prev_u_reg <= ui;
            prev_v_reg <= vi;
        end
        du_reg     <= $signed({1'b0, pu_reg}) - $signed({1'b0, ui});
        duj_reg    <= $signed({1'b0, prev_u_reg}) - $signed({1'b0, ui});
        dpv_reg    <= $signed({1'b0, pv_reg}) - $signed({1'b0, vi});
        dv_reg     <= $signed({1'b0, prev_v_reg}) - $signed({1'b0, vi});
        dvpos2_reg <= prev_v_reg > vi;
    end

    // Product stage: cross-multiplied form of the crossing abscissa test.
    always_ff @(posedge clk)
    begin
        lhs_reg    <= du_reg * dv_reg;
        rhs_reg    <= duj_reg * dpv_reg;
        dvpos3_reg <= dvpos2_reg;
    end

    // The comparison direction follows the sign of the edge height.
    assign left = dvpos3_reg ? (lhs_reg < rhs_reg) : (lhs_reg > rhs_reg);

    // Even-odd parity of the crossings to the right of the point.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg <= 1'b0;
        end
        else if (cmd.clear_parity)
        begin
            parity_reg <= 1'b0;
        end
        else if (cross3_reg && left)
        begin
            parity_reg <= !parity_reg;
        end
    end

    assign status.in_poly = parity_reg;

endmodule

/* src/php_ctrl.sv */
`timescale 1ns / 1ps

module php_ctrl
    import php_pkg::*;
#(
    parameter int MAX_POLYGONS = DEF_MAX_POLYGONS,
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    localparam int PW   = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1,
    localparam int KW   = $clog2(MAX_POLYGONS + 1),
    localparam int VW   = $clog2(MAX_VERTICES),
    localparam int CNTW = $clog2(MAX_VERTICES + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              operation,
    output logic              busy,
    input  logic [CFG_W-1:0]  polygons_in_use,
    output php_cmd_t          cmd,
    input  php_status_t       status,
    output logic [PW-1:0]     rd_poly,
    output logic [VW-1:0]     rd_vert,
    input  logic [CNTW-1:0]   poly_count,
    output logic              done,
    output logic              hit,
    output logic [SLOT_W-1:0] polygon_found
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_POLY  = 4'b0010,
        S_ISSUE = 4'b0100,
        S_DRAIN = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [VW-1:0]     vidx_reg, vidx_next;
    logic              first_reg, first_next;
    logic [1:0]        drain_reg, drain_next;
    logic              done_reg, done_next;
    logic              hit_reg, hit_next;
    logic [SLOT_W-1:0] found_reg, found_next;
    logic [KW-1:0]     limit;
    logic [VW-1:0]     last_vert;

    // Slots searched, saturated to the table size.
    assign limit = (polygons_in_use > MAX_POLYGONS) ? KW'(MAX_POLYGONS)
                                                    : KW'(polygons_in_use);
    assign last_vert = VW'(poly_count - CNTW'(1));

    assign busy          = (state_reg != S_IDLE);
    assign rd_poly       = PW'(k_reg);
    assign rd_vert       = vidx_reg;
    assign done          = done_reg;
    assign hit           = hit_reg;
    assign polygon_found = found_reg;

    // Next-state and command logic of the search sequencer.
    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        vidx_next   = vidx_reg;
        first_next  = first_reg;
        drain_next  = drain_reg;
        done_next   = 1'b0;
        hit_next    = hit_reg;
        found_next  = found_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.write_vertex = start && (operation == OP_WRITE);
                if (start && (operation == OP_QUERY))
                begin
                    cmd.load_point = 1'b1;
                    k_next         = '0;
                    state_next     = S_POLY;
                end
            end
            S_POLY:
            begin
                if (k_reg >= limit)
                begin
                    done_next  = 1'b1;
                    hit_next   = 1'b0;
                    found_next = '0;
                    state_next = S_IDLE;
                end
                else if (poly_count < CNTW'(MIN_VERTS))
                begin
                    k_next = k_reg + KW'(1);
                end
                else
                begin
                    // Start with the closing vertex so the first edge wraps around.
                    cmd.clear_parity = 1'b1;
                    vidx_next        = last_vert;
                    first_next       = 1'b1;
                    state_next       = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = first_reg;
                if (first_reg)
                begin
                    first_next = 1'b0;
                    vidx_next  = '0;
                end
                else if (vidx_reg == last_vert)
                begin
                    drain_next = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    vidx_next = vidx_reg + VW'(1);
                end
            end
            S_DRAIN:
            begin
                if (drain_reg == DRAIN_LAST)
                begin
                    if (status.in_poly)
                    begin
                        done_next  = 1'b1;
                        hit_next   = 1'b1;
                        found_next = SLOT_W'(k_reg);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + KW'(1);
                        state_next = S_POLY;
                    end
                end
                else
                begin
                    drain_next = drain_reg + 2'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Controller registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            vidx_reg  <= '0;
            first_reg <= 1'b0;
            drain_reg <= '0;
            done_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            found_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            vidx_reg  <= vidx_next;
            first_reg <= first_next;
            drain_reg <= drain_next;
            done_reg  <= done_next;
            hit_reg   <= hit_next;
            found_reg <= found_next;
        end
    end

endmodule

/* src/polygon_hotspot_pick.sv */
`timescale 1ns / 1ps

// Polygon hotspot picker: finds the lowest polygon slot containing a point.
// Item channel: an item is taken at a rising edge with start high and busy low.
// A vertex write (operation 0) stores (coord_u, coord_v) at polygon_slot and
// vertex_slot, gives no result, and leaves busy low, so writes may follow each
// other in every cycle. The last-vertex mark sets the count.
// A query (operation 1) raises busy and gives exactly one result on done, hit
// and polygon_found, shown for a single cycle; the receiver cannot stall it.
// Query walk: a polygon with fewer than 3 vertices is skipped; else its
// closing vertex and then its n vertices are read, one edge test a cycle
// through the single read port of the vertex memory, and the edge pipeline
// is drained before its parity is read. The walk stops at the first polygon
// that hits; a miss is reported once every slot in use has been walked.
// Configuration: APB register polygons_in_use at address 0, written by the user
// only while idle; the block does not enforce it. Reset clears all vertex
// counts and the register; vertex memory contents are undefined until written.

module polygon_hotspot_pick
    import php_pkg::*;
#(
    parameter int MAX_POLYGONS    = DEF_MAX_POLYGONS,
    parameter int MAX_VERTICES    = DEF_MAX_VERTICES,
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready,
    input  logic                     start,
    output logic                     busy,
    input  logic                     operation,
    input  logic [SLOT_W-1:0]        polygon_slot,
    input  logic [SLOT_W-1:0]        vertex_slot,
    input  logic                     vertex_last,
    input  logic [COORD_FRAC_BITS:0] coord_u,
    input  logic [COORD_FRAC_BITS:0] coord_v,
    output logic                     done,
    output logic                     hit,
    output logic [SLOT_W-1:0]        polygon_found
);

    localparam int PW   = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1;
    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);

    logic [CFG_W-1:0] polygons_in_use_reg;
    logic             cfg_wr;
    php_cmd_t         cmd;
    php_status_t      status;
    logic [PW-1:0]    rd_poly;
    logic [VW-1:0]    rd_vert;
    logic [CNTW-1:0]  poly_count;

    // Configuration register; addresses beyond the map are ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[APB_AW-1] == REG_POLYGONS_IN_USE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            polygons_in_use_reg <= '0;
        end
        else if (cfg_wr)
        begin
            polygons_in_use_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[APB_AW-1] == REG_POLYGONS_IN_USE)
                    ? {{(APB_DW-CFG_W){1'b0}}, polygons_in_use_reg} : '0;

    php_ctrl #(
        .MAX_POLYGONS (MAX_POLYGONS),
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .operation       (operation),
        .busy            (busy),
        .polygons_in_use (polygons_in_use_reg),
        .cmd             (cmd),
        .status          (status),
        .rd_poly         (rd_poly),
        .rd_vert         (rd_vert),
        .poly_count      (poly_count),
        .done            (done),
        .hit             (hit),
        .polygon_found   (polygon_found)
    );

    php_dp #(
        .MAX_POLYGONS    (MAX_POLYGONS),
        .MAX_VERTICES    (MAX_VERTICES),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .rd_poly      (rd_poly),
        .rd_vert      (rd_vert),
        .poly_count   (poly_count),
        .polygon_slot (polygon_slot),
        .vertex_slot  (vertex_slot),
        .vertex_last  (vertex_last),
        .coord_u      (coord_u),
        .coord_v      (coord_v)
    );

endmodule

/* src/php_checker.sv */
`timescale 1ns / 1ps

module php_checker
    import php_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              operation,
    input logic              busy,
    input logic              done,
    input logic              hit,
    input logic [SLOT_W-1:0] polygon_found
);

    // A result ends a search, so the block was busy just before it.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result without a preceding search");

    // The block is back to idle when the result is shown.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while still busy");

    // Only an accepted query starts a search.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && (operation == OP_QUERY)))
        else $error("busy raised without a query item");

    // A miss reports slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (polygon_found == '0))
        else $error("no-hit result carries a nonzero slot");

    // Each query gives one result, never two in a row.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result repeated");

endmodule

bind polygon_hotspot_pick php_checker u_php_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .operation     (operation),
    .busy          (busy),
    .done          (done),
    .hit           (hit),
    .polygon_found (polygon_found)
);
